FILE: design/tedrs_pkg.sv
// shared types and constants for the touch event decoder
// no dependencies; imported by every module of the block

package tedrs_pkg;

   // event codes
   localparam logic [15:0] EVT_SYNC    = 16'd0;
   localparam logic [15:0] EVT_KEY     = 16'd1;
   localparam logic [15:0] EVT_ABS     = 16'd3;
   localparam logic [15:0] CODE_TOUCH  = 16'd330;
   localparam logic [15:0] CODE_AXIS_X = 16'd0;
   localparam logic [15:0] CODE_AXIS_Y = 16'd1;

   // emitted point kinds
   localparam logic KIND_PRESS   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_ROTATION  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCREEN_W  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SCREEN_H  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RAW_X_MIN = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RAW_X_MAX = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_RAW_Y_MIN = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_RAW_Y_MAX = 3'd6;

   // rotation codes
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   // register reset values
   localparam logic [1:0]         RST_ROTATION  = 2'd0;
   localparam logic [13:0]        RST_SCREEN_W  = 14'd800;
   localparam logic [13:0]        RST_SCREEN_H  = 14'd480;
   localparam logic signed [15:0] RST_RAW_MIN   = 16'sd0;
   localparam logic signed [15:0] RST_RAW_MAX   = 16'sd4095;

   // datapath widths
   localparam int SCREEN_W   = 14;
   localparam int SIZE_W     = SCREEN_W + 1;      // screen size as a signed operand
   localparam int RAW_W      = 16;
   localparam int SPAN_W     = RAW_W + 1;         // max - min
   localparam int HELD_W     = 32;
   localparam int COORD_W    = HELD_W + 2;        // size - held - 1 without wrap
   localparam int PROD_W     = SIZE_W + COORD_W;
   localparam int DIVIDEND_W = PROD_W - 1;        // magnitude of the product
   localparam int DIVISOR_W  = SPAN_W - 1;        // magnitude of the span
   localparam int POS_W      = 32;

   // shift-subtract divider: bits retired per cycle, iteration count and its counter width
   localparam int DIV_STEPS_PER_CYCLE = 2;
   localparam int DIV_CYCLES  = DIVIDEND_W / DIV_STEPS_PER_CYCLE;
   localparam int DIV_COUNT_W = $clog2(DIV_CYCLES);

   typedef struct packed {
      logic [15:0]        ev_type;
      logic [15:0]        ev_code;
      logic signed [31:0] ev_value;
   } req_payload_type;

   typedef struct packed {
      logic               touch_kind;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic latch_x;
      logic latch_y;
      logic rot_load;
      logic mul_load;
      logic div_init;
      logic div_step;
      logic rsp_load;
      logic kind;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_key_touch;
      logic key_down;
      logic is_abs_x;
      logic is_abs_y;
      logic is_sync;
      logic rsp_free;
   } dp_status_type;

endpackage

FILE: design/tedrs_div.sv
// unsigned shift-subtract divider, a few quotient bits per cycle
// depends on tedrs_pkg for widths and steps per cycle

module tedrs_div import tedrs_pkg::*; (
   input  logic                  clock,
   input  logic                  init,
   input  logic                  step,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [POS_W-1:0]      quotient
);

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [DIVISOR_W-1:0]  div_ff;

   // num shifts out dividend bits at the top and takes quotient bits at the bottom
   always_comb begin
      logic [DIVISOR_W:0]    trial;
      logic [DIVISOR_W-1:0]  r;
      logic [DIVIDEND_W-1:0] n;
      r = rem_ff;
      n = num_ff;
      for (int i = 0; i < DIV_STEPS_PER_CYCLE; i++) begin
         trial = {r, n[DIVIDEND_W-1]};
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
            n = {n[DIVIDEND_W-2:0], 1'b1};
         end else begin
            n = {n[DIVIDEND_W-2:0], 1'b0};
         end
         r = trial[DIVISOR_W-1:0];
      end
      rem_in = r;
      num_in = n;
   end

   always_ff @(posedge clock) begin
      if (init) begin
         rem_ff <= '0;
         num_ff <= dividend;
         div_ff <= divisor;
      end else if (step) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
      end
   end

   assign quotient = num_ff[POS_W-1:0];

endmodule

FILE: design/tedrs_dp.sv
// datapath: config registers, held coordinates, rotation, multiply,
// two divider lanes and the result register; uses tedrs_pkg and tedrs_div

module tedrs_dp import tedrs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  req_payload_type        req_payload,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output rsp_payload_type        rsp_payload,
   input  dp_cmd_type             cmd,
   output dp_status_type          status
);

   logic [1:0]               rotation_ff;
   logic [SCREEN_W-1:0]      width_ff, height_ff;
   logic signed [RAW_W-1:0]  x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic signed [HELD_W-1:0] held_x_ff, held_y_ff;

   logic signed [COORD_W-1:0] cx_ff, cy_ff, cx_in, cy_in;
   logic signed [SPAN_W-1:0]  sx_ff, sy_ff, sx_in, sy_in;
   logic signed [PROD_W-1:0]  prod_x_ff, prod_y_ff;
   logic signed [SIZE_W-1:0]  size_x, size_y;
   logic [PROD_W-1:0]         mag_x, mag_y;
   logic [SPAN_W-1:0]         dmag_x, dmag_y;
   logic                      neg_x_ff, neg_y_ff, zero_x_ff, zero_y_ff;
   logic [POS_W-1:0]          q_x, q_y, pos_x_in, pos_y_in;
   logic                      rsp_valid_ff;
   rsp_payload_type           rsp_payload_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff <= RST_ROTATION;
         width_ff    <= RST_SCREEN_W;
         height_ff   <= RST_SCREEN_H;
         x_min_ff    <= RST_RAW_MIN;
         x_max_ff    <= RST_RAW_MAX;
         y_min_ff    <= RST_RAW_MIN;
         y_max_ff    <= RST_RAW_MAX;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_ROTATION:  rotation_ff <= csr_data[1:0];
            REG_SCREEN_W:  width_ff    <= csr_data[SCREEN_W-1:0];
            REG_SCREEN_H:  height_ff   <= csr_data[SCREEN_W-1:0];
            REG_RAW_X_MIN: x_min_ff    <= $signed(csr_data);
            REG_RAW_X_MAX: x_max_ff    <= $signed(csr_data);
            REG_RAW_Y_MIN: y_min_ff    <= $signed(csr_data);
            REG_RAW_Y_MAX: y_max_ff    <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // event decode
   always_comb begin
      status.is_key_touch = (req_payload.ev_type == EVT_KEY)
                            && (req_payload.ev_code == CODE_TOUCH);
      status.key_down     = (req_payload.ev_value != '0);
      status.is_abs_x     = (req_payload.ev_type == EVT_ABS)
                            && (req_payload.ev_code == CODE_AXIS_X);
      status.is_abs_y     = (req_payload.ev_type == EVT_ABS)
                            && (req_payload.ev_code == CODE_AXIS_Y);
      status.is_sync      = (req_payload.ev_type == EVT_SYNC);
      status.rsp_free     = !rsp_valid_ff || !rsp_stall;
   end

   // held raw coordinates
   always_ff @(posedge clock) begin
      if (reset) begin
         held_x_ff <= '0;
         held_y_ff <= '0;
      end else begin
         if (cmd.latch_x) held_x_ff <= req_payload.ev_value;
         if (cmd.latch_y) held_y_ff <= req_payload.ev_value;
      end
   end

   // rotation by quarter turns
   always_comb begin
      logic signed [COORD_W-1:0] hx, hy, wz, hz;
      logic signed [SPAN_W-1:0]  span_x, span_y;
      hx = {{(COORD_W-HELD_W){held_x_ff[HELD_W-1]}}, held_x_ff};
      hy = {{(COORD_W-HELD_W){held_y_ff[HELD_W-1]}}, held_y_ff};
      wz = $signed({{(COORD_W-SCREEN_W){1'b0}}, width_ff});
      hz = $signed({{(COORD_W-SCREEN_W){1'b0}}, height_ff});
      span_x = $signed({x_max_ff[RAW_W-1], x_max_ff}) - $signed({x_min_ff[RAW_W-1], x_min_ff});
      span_y = $signed({y_max_ff[RAW_W-1], y_max_ff}) - $signed({y_min_ff[RAW_W-1], y_min_ff});
      unique case (rotation_ff)
         ROT_90: begin
            cx_in = hy;
            cy_in = hz - hx - COORD_W'(1);
            sx_in = span_y;
            sy_in = span_x;
         end
         ROT_180: begin
            cx_in = wz - hx - COORD_W'(1);
            cy_in = hz - hy - COORD_W'(1);
            sx_in = span_x;
            sy_in = span_y;
         end
         ROT_270: begin
            cx_in = wz - hy - COORD_W'(1);
            cy_in = hx;
            sx_in = span_y;
            sy_in = span_x;
         end
         default: begin
            cx_in = hx;
            cy_in = hy;
            sx_in = span_x;
            sy_in = span_y;
         end
      endcase
   end

   assign size_x = $signed({1'b0, width_ff});
   assign size_y = $signed({1'b0, height_ff});

   // magnitudes for the unsigned divider
   assign mag_x  = prod_x_ff[PROD_W-1] ? (~prod_x_ff + 1'b1) : prod_x_ff;
   assign mag_y  = prod_y_ff[PROD_W-1] ? (~prod_y_ff + 1'b1) : prod_y_ff;
   assign dmag_x = sx_ff[SPAN_W-1] ? (~sx_ff + 1'b1) : sx_ff;
   assign dmag_y = sy_ff[SPAN_W-1] ? (~sy_ff + 1'b1) : sy_ff;

   always_ff @(posedge clock) begin
      if (cmd.rot_load) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         sx_ff <= sx_in;
         sy_ff <= sy_in;
      end
      if (cmd.mul_load) begin
         prod_x_ff <= size_x * cx_ff;
         prod_y_ff <= size_y * cy_ff;
      end
      if (cmd.div_init) begin
         neg_x_ff  <= prod_x_ff[PROD_W-1] ^ sx_ff[SPAN_W-1];
         neg_y_ff  <= prod_y_ff[PROD_W-1] ^ sy_ff[SPAN_W-1];
         zero_x_ff <= (sx_ff == '0);
         zero_y_ff <= (sy_ff == '0);
      end
   end

   tedrs_div u_div_x (
      .clock    (clock),
      .init     (cmd.div_init),
      .step     (cmd.div_step),
      .dividend (mag_x[DIVIDEND_W-1:0]),
      .divisor  (dmag_x[DIVISOR_W-1:0]),
      .quotient (q_x)
   );

   tedrs_div u_div_y (
      .clock    (clock),
      .init     (cmd.div_init),
      .step     (cmd.div_step),
      .dividend (mag_y[DIVIDEND_W-1:0]),
      .divisor  (dmag_y[DIVISOR_W-1:0]),
      .quotient (q_y)
   );

   // sign fix, zero span gives zero
   always_comb begin
      if (zero_x_ff)     pos_x_in = '0;
      else if (neg_x_ff) pos_x_in = ~q_x + 1'b1;
      else               pos_x_in = q_x;
      if (zero_y_ff)     pos_y_in = '0;
      else if (neg_y_ff) pos_y_in = ~q_y + 1'b1;
      else               pos_y_in = q_y;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_payload_ff.touch_kind <= cmd.kind;
         rsp_payload_ff.pos_x      <= $signed(pos_x_in);
         rsp_payload_ff.pos_y      <= $signed(pos_y_in);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: design/tedrs_ctrl.sv
// controller: touch mode state machine and point computation sequencer
// depends on tedrs_pkg for command and status structs

module tedrs_ctrl import tedrs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_ROT, S_MUL, S_INIT, S_DIV, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      MODE_IDLE, MODE_PRESS, MODE_MOVE, MODE_RELEASE
   } mode_type;

   state_type              state_ff, state_in;
   mode_type               mode_ff, mode_in;
   logic                   kind_ff, kind_in;
   logic [DIV_COUNT_W-1:0] count_ff, count_in;
   logic                   accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd          = '0;
      cmd.latch_x  = accept && status.is_abs_x && (mode_ff == MODE_PRESS);
      cmd.latch_y  = accept && status.is_abs_y && (mode_ff == MODE_PRESS);
      cmd.rot_load = (state_ff == S_ROT);
      cmd.mul_load = (state_ff == S_MUL);
      cmd.div_init = (state_ff == S_INIT);
      cmd.div_step = (state_ff == S_DIV);
      cmd.rsp_load = (state_ff == S_OUT) && status.rsp_free;
      cmd.kind     = kind_ff;
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      kind_in  = kind_ff;
      count_in = count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (status.is_key_touch) begin
                  mode_in = status.key_down ? MODE_PRESS : MODE_RELEASE;
               end else if (status.is_sync && (mode_ff == MODE_PRESS)) begin
                  mode_in  = MODE_MOVE;
                  kind_in  = KIND_PRESS;
                  state_in = S_ROT;
               end else if (status.is_sync && (mode_ff == MODE_RELEASE)) begin
                  mode_in  = MODE_IDLE;
                  kind_in  = KIND_RELEASE;
                  state_in = S_ROT;
               end
            end
         end
         S_ROT:  state_in = S_MUL;
         S_MUL:  state_in = S_INIT;
         S_INIT: begin
            count_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (count_ff == DIV_COUNT_W'(DIV_CYCLES - 1)) begin
               state_in = S_OUT;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         S_OUT: begin
            if (status.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= MODE_IDLE;
         kind_ff  <= KIND_PRESS;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         kind_ff  <= kind_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/touch_event_decode_rotate_scale.sv
// touch event decoder: key, axis and sync events in, rotated and scaled points out
// sequence: key, axis and ignored events give no beat; a sync that emits a point goes
// through rotate, multiply, divider init, divide and output states to the result register;
// the shift-subtract divider takes 48 quotient bits, 2 per cycle, x and y lanes side by side
// throughput: one event per cycle, but none is taken while a point is computed or waits
// reset: synchronous, clears touch mode, held coordinates and result valid, config defaults

module touch_event_decode_rotate_scale import tedrs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // configuration writes
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   // event input
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   // point output
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload
);

   // command and status between sequencer and datapath
   dp_cmd_type    cmd;
   dp_status_type status;

   // touch mode and computation sequencing
   tedrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // config, held coordinates, rotate, multiply, divide, result register
   tedrs_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_payload  (req_payload),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload),
      .cmd          (cmd),
      .status       (status)
   );

   // result register only loads when it is empty or draining
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.rsp_free)
      else $error("result loaded over a waiting beat");

   // rotation stage is always followed by the multiply stage
   assert property (@(posedge clock) disable iff (reset)
      cmd.rot_load |=> cmd.mul_load)
      else $error("multiply stage skipped");

   // held coordinates never change while a point is being divided
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !(cmd.latch_x || cmd.latch_y))
      else $error("coordinate latched during divide");

   // a new result beat only appears after a result load
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.rsp_load))
      else $error("result valid without a load");

endmodule

FILE: tb/touch_event_decode_rotate_scale_tb.sv
// self-checking testbench for the touch event decoder with rotation and scaling
// depends on tedrs_pkg and touch_event_decode_rotate_scale; predicts each point in
// place and checks every output beat against it under random bursts and stalls

module touch_event_decode_rotate_scale_tb;
   import tedrs_pkg::*;

   localparam int HALF_PERIOD      = 10;
   localparam int RESET_CYCLES     = 8;
   localparam int SETTLE_CYCLES    = 40;
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int ITEMS_PER_PHASE  = 70;
   localparam int REPORT_LIMIT     = 10;

   // codes the package does not name
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;
   localparam logic [15:0] EVT_OTHER  = 16'd2;
   localparam logic [15:0] CODE_OTHER = 16'd2;

   typedef enum logic [1:0] {
      TOUCH_IDLE,
      TOUCH_PRESSED,
      TOUCH_MOVING,
      TOUCH_RELEASED
   } touch_mode_type;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_data     = '0;
   logic                   req_valid    = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall    = 1'b0;
   rsp_payload_type        rsp_payload;

   touch_event_decode_rotate_scale u_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------------------
   // mirror of the block: touch mode, held raw coordinates and register copies
   // ---------------------------------------------------------------------------
   touch_mode_type     touch_mode   = TOUCH_IDLE;
   logic signed [31:0] held_x       = '0;
   logic signed [31:0] held_y       = '0;
   logic [1:0]         cfg_rotation = RST_ROTATION;
   logic [13:0]        cfg_screen_w = RST_SCREEN_W;
   logic [13:0]        cfg_screen_h = RST_SCREEN_H;
   logic signed [15:0] cfg_x_min    = RST_RAW_MIN;
   logic signed [15:0] cfg_x_max    = RST_RAW_MAX;
   logic signed [15:0] cfg_y_min    = RST_RAW_MIN;
   logic signed [15:0] cfg_y_max    = RST_RAW_MAX;

   // points predicted but not yet seen on the output, oldest first
   rsp_payload_type    pending_points[$];

   // run bookkeeping
   int          mismatch_count   = 0;
   int          events_counted   = 0;   // sync, key and axis beats only
   int          beats_sent       = 0;
   int          press_points     = 0;
   int          release_points   = 0;
   int          settings_applied = 0;
   int unsigned cycle_count      = 0;

   // sender burst shaping
   bit req_raised = 1'b0;
   int burst_left = 0;

   // size * coord / span at 64 bits, truncated toward zero, low 32 bits kept
   function automatic logic signed [31:0] scale_axis(longint size, longint coord,
                                                     longint span);
      longint q;
      if (span == 0)
         return '0;
      q = (size * coord) / span;
      return q[31:0];
   endfunction

   // advance the mirror by one accepted event and queue the point it emits, if any
   function automatic void predict_touch_point(req_payload_type ev);
      rsp_payload_type pt;
      longint          w, h, span_x, span_y, cx, cy, sx, sy, hx, hy;
      logic            emit;
      w      = longint'(cfg_screen_w);
      h      = longint'(cfg_screen_h);
      span_x = longint'(cfg_x_max) - longint'(cfg_x_min);
      span_y = longint'(cfg_y_max) - longint'(cfg_y_min);
      emit   = 1'b0;
      pt     = '0;
      case (ev.ev_type)
         EVT_KEY: begin
            if (ev.ev_code == CODE_TOUCH)
               touch_mode = (ev.ev_value != 0) ? TOUCH_PRESSED : TOUCH_RELEASED;
         end
         EVT_ABS: begin
            // axis values only latch while the finger is freshly down
            if (touch_mode == TOUCH_PRESSED) begin
               if (ev.ev_code == CODE_AXIS_X)
                  held_x = ev.ev_value;
               if (ev.ev_code == CODE_AXIS_Y)
                  held_y = ev.ev_value;
            end
         end
         EVT_SYNC: begin
            if (touch_mode == TOUCH_PRESSED) begin
               touch_mode    = TOUCH_MOVING;
               pt.touch_kind = KIND_PRESS;
               emit          = 1'b1;
            end else if (touch_mode == TOUCH_RELEASED) begin
               touch_mode    = TOUCH_IDLE;
               pt.touch_kind = KIND_RELEASE;
               emit          = 1'b1;
            end
         end
         default: ;
      endcase
      if (!emit)
         return;
      hx = longint'(held_x);
      hy = longint'(held_y);
      // quarter turns swap axes and mirror against the screen edge
      case (cfg_rotation)
         ROT_90: begin
            cx = hy;          cy = h - hx - 1;  sx = span_y;  sy = span_x;
         end
         ROT_180: begin
            cx = w - hx - 1;  cy = h - hy - 1;  sx = span_x;  sy = span_y;
         end
         ROT_270: begin
            cx = w - hy - 1;  cy = hx;          sx = span_y;  sy = span_x;
         end
         default: begin
            cx = hx;          cy = hy;          sx = span_x;  sy = span_y;
         end
      endcase
      pt.pos_x = scale_axis(w, cx, sx);
      pt.pos_y = scale_axis(h, cy, sy);
      pending_points.push_back(pt);
   endfunction

   function automatic void store_setting(logic [CSR_INDEX_W-1:0] idx,
                                         logic [CSR_DATA_W-1:0] d);
      case (idx)
         REG_ROTATION:  cfg_rotation = d[1:0];
         REG_SCREEN_W:  cfg_screen_w = d[13:0];
         REG_SCREEN_H:  cfg_screen_h = d[13:0];
         REG_RAW_X_MIN: cfg_x_min    = d;
         REG_RAW_X_MAX: cfg_x_max    = d;
         REG_RAW_Y_MIN: cfg_y_min    = d;
         REG_RAW_Y_MAX: cfg_y_max    = d;
         default: ;     // unused index, write dropped
      endcase
   endfunction

   function automatic void flag_mismatch(string what, longint want, longint got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
                  what, cycle_count, want, got);
   endfunction

   // ---------------------------------------------------------------------------
   // output side: stall pattern and point checker
   // ---------------------------------------------------------------------------
   int stall_left  = 0;
   int stall_style = 0;

   // stall styles: none, light, heavy, and square bursts
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_left  = $urandom_range(10, 120);
      end else begin
         stall_left--;
      end
      case (stall_style)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_left[2];
      endcase
   end

   // each output beat is held against the oldest predicted point
   always @(posedge clock) begin : check_points
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected point at cycle %0d: kind %0d x %0d y %0d",
                        cycle_count, rsp_payload.touch_kind, rsp_payload.pos_x,
                        rsp_payload.pos_y);
         end else begin
            want = pending_points.pop_front();
            if (rsp_payload.touch_kind !== want.touch_kind)
               flag_mismatch("touch_kind", longint'(want.touch_kind),
                             longint'(rsp_payload.touch_kind));
            if (rsp_payload.pos_x !== want.pos_x)
               flag_mismatch("pos_x", longint'(want.pos_x), longint'(rsp_payload.pos_x));
            if (rsp_payload.pos_y !== want.pos_y)
               flag_mismatch("pos_y", longint'(want.pos_y), longint'(rsp_payload.pos_y));
            if (want.touch_kind == KIND_PRESS)
               press_points++;
            else
               release_points++;
         end
      end
   end

   // runaway guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d points outstanding",
                  cycle_count, pending_points.size());
         $display("touch_event_decode_rotate_scale verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // input side
   // ---------------------------------------------------------------------------

   // one input beat; valid stays up across a burst and drops for a random gap after it
   task automatic post_event(input logic [15:0] ev_type, input logic [15:0] ev_code,
                             input logic [31:0] ev_value);
      req_payload_type ev;
      ev.ev_type  = ev_type;
      ev.ev_code  = ev_code;
      ev.ev_value = ev_value;
      req_payload <= ev;
      req_valid   <= 1'b1;
      req_raised   = 1'b1;
      do @(posedge clock); while (req_stall);
      predict_touch_point(ev);
      beats_sent++;
      if (ev_type == EVT_SYNC || ev_type == EVT_KEY || ev_type == EVT_ABS)
         events_counted++;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         req_raised = 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         // one burst in four is long enough to run with no gaps at all
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(0, 6);
      end else begin
         burst_left--;
      end
   endtask

   task automatic hold_off();
      if (req_raised) begin
         req_valid <= 1'b0;
         req_raised = 1'b0;
      end
   endtask

   // stop sending and wait for every predicted point, waiting on the clock even when none is pending
   task automatic await_points();
      hold_off();
      do @(posedge clock); while (pending_points.size() != 0);
   endtask

   // drained and quiet: key and axis beats leave nothing behind to wait for
   task automatic settle_block();
      await_points();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [1:0] rot, input logic [13:0] sw,
                                input logic [13:0] sh, input logic signed [15:0] x_lo,
                                input logic signed [15:0] x_hi,
                                input logic signed [15:0] y_lo,
                                input logic signed [15:0] y_hi, input bit poke_unused);
      logic [CSR_INDEX_W-1:0] idx [7];
      logic [CSR_DATA_W-1:0]  val [7];
      idx = '{REG_ROTATION, REG_SCREEN_W, REG_SCREEN_H, REG_RAW_X_MIN, REG_RAW_X_MAX,
              REG_RAW_Y_MIN, REG_RAW_Y_MAX};
      val = '{16'(rot), 16'(sw), 16'(sh), x_lo, x_hi, y_lo, y_hi};
      settle_block();
      for (int i = 0; i < 7; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= idx[i];
         csr_data     <= val[i];
         @(posedge clock);
         store_setting(idx[i], val[i]);
      end
      if (poke_unused) begin
         csr_index <= REG_UNUSED;
         csr_data  <= 16'($urandom);
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      settings_applied++;
   endtask

   function automatic logic [31:0] key_down_value();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 3))
         0:       return 32'd1;
         1:       return 32'h8000_0000;
         default: return (v == 0) ? 32'd1 : v;
      endcase
   endfunction

   // raw coordinate: mostly inside the sensor range, sometimes wild or at the rails
   function automatic logic [31:0] axis_value(bit on_y);
      logic signed [15:0] a, b;
      int                 lo, hi;
      a  = on_y ? cfg_y_min : cfg_x_min;
      b  = on_y ? cfg_y_max : cfg_x_max;
      lo = (a < b) ? int'(a) : int'(b);
      hi = (a < b) ? int'(b) : int'(a);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'd0;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return lo + int'($urandom_range(hi - lo));
      endcase
   endfunction

   task automatic post_axis();
      bit on_y;
      on_y = 1'($urandom_range(0, 1));
      post_event(EVT_ABS, on_y ? CODE_AXIS_Y : CODE_AXIS_X, axis_value(on_y));
   endtask

   task automatic post_sync();
      post_event(EVT_SYNC, 16'($urandom), $urandom);
   endtask

   // touch down, position, sync, some motion, lift, sync
   task automatic play_gesture();
      post_event(EVT_KEY, CODE_TOUCH, key_down_value());
      repeat ($urandom_range(0, 3)) post_axis();
      post_sync();
      repeat ($urandom_range(0, 2)) begin
         post_axis();
         post_sync();
      end
      if ($urandom_range(0, 3) == 0) begin
         post_event(EVT_KEY, CODE_TOUCH, key_down_value());
         post_axis();
         post_sync();
      end
      post_event(EVT_KEY, CODE_TOUCH, 32'd0);
      if ($urandom_range(0, 2) == 0)
         post_axis();
      post_sync();
   endtask

   // short runs of meaningful event types in no particular order
   task automatic play_broken();
      logic [15:0] ev_type, ev_code;
      logic [31:0] ev_value;
      repeat ($urandom_range(1, 5)) begin
         case ($urandom_range(0, 2))
            0:       ev_type = EVT_SYNC;
            1:       ev_type = EVT_KEY;
            default: ev_type = EVT_ABS;
         endcase
         case ($urandom_range(0, 3))
            0:       ev_code = CODE_TOUCH;
            1:       ev_code = CODE_AXIS_X;
            2:       ev_code = CODE_AXIS_Y;
            default: ev_code = 16'($urandom);
         endcase
         ev_value = ($urandom_range(0, 2) == 0) ? 32'd0
                                                 : axis_value(1'($urandom_range(0, 1)));
         post_event(ev_type, ev_code, ev_value);
      end
   endtask

   // mostly gestures, some broken runs, a little pure noise
   task automatic run_traffic(input int n);
      int target, pick;
      target = events_counted + n;
      while (events_counted < target) begin
         if ($urandom_range(0, 24) == 0)
            await_points();
         pick = $urandom_range(0, 9);
         if (pick < 7)
            play_gesture();
         else if (pick < 9)
            play_broken();
         else
            post_event(16'($urandom), 16'($urandom), $urandom);
      end
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // events that must change nothing, with the decoder idle
   task automatic test_ignored_events();
      post_event(EVT_SYNC, CODE_AXIS_X, 32'd0);          // sync while idle
      post_event(EVT_ABS, CODE_AXIS_X, 32'd1234);        // axis while idle, not latched
      post_event(EVT_OTHER, CODE_TOUCH, 32'd1);
      post_event(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      post_event(EVT_KEY, 16'hFFFF, 32'd1);              // key that is not the touch key
      post_event(EVT_KEY, CODE_AXIS_X, 32'd1);
      await_points();
   endtask

   // press and release paths under reset registers, with extreme field values
   task automatic test_press_release_cycle();
      post_event(EVT_KEY, CODE_TOUCH, 32'h8000_0000);    // negative value still means down
      post_event(EVT_ABS, CODE_OTHER, 32'd5);            // unknown axis
      post_event(EVT_ABS, 16'hFFFF, 32'd6);
      post_event(EVT_ABS, CODE_AXIS_X, 32'h7FFF_FFFF);
      post_event(EVT_ABS, CODE_AXIS_Y, 32'h8000_0000);
      post_event(EVT_SYNC, 16'hFFFF, 32'hFFFF_FFFF);     // press point
      post_event(EVT_SYNC, CODE_AXIS_X, 32'd0);          // moving, nothing out
      post_event(EVT_ABS, CODE_AXIS_X, 32'd7);           // moving, not latched
      post_event(EVT_KEY, CODE_TOUCH, 32'd0);
      post_event(EVT_SYNC, CODE_AXIS_X, 32'd0);          // release at extreme held point
      post_event(EVT_KEY, CODE_TOUCH, 32'd1);
      post_event(EVT_ABS, CODE_AXIS_X, 32'd0);
      post_event(EVT_ABS, CODE_AXIS_Y, 32'd4095);
      post_event(EVT_SYNC, CODE_AXIS_X, 32'd0);
      post_event(EVT_KEY, CODE_TOUCH, 32'd0);
      post_event(EVT_SYNC, CODE_AXIS_X, 32'd0);
      post_event(EVT_KEY, CODE_TOUCH, 32'hFFFF_FFFF);
      post_event(EVT_ABS, CODE_AXIS_X, 32'd4095);
      post_event(EVT_KEY, CODE_TOUCH, 32'd0);            // lift before any sync
      post_event(EVT_SYNC, CODE_AXIS_X, 32'd0);
      post_event(EVT_KEY, CODE_TOUCH, 32'd0);            // lift from idle still releases
      post_event(EVT_SYNC, CODE_AXIS_X, 32'd0);
      await_points();
   endtask

   // register corners: full range, tiny screen, zero spans, zero size, reversed spans
   task automatic test_register_extremes();
      apply_setting(ROT_0, 14'd8192, 14'd8192, -16'sd32768, 16'sd32767,
                    -16'sd32768, 16'sd32767, 1'b0);
      run_traffic(ITEMS_PER_PHASE);
      apply_setting(ROT_90, 14'd1, 14'd1, 16'sd0, 16'sd1, -16'sd1, 16'sd0, 1'b1);
      run_traffic(ITEMS_PER_PHASE);
      apply_setting(ROT_180, 14'd640, 14'd8192, 16'sd100, 16'sd100,
                    -16'sd32768, 16'sd32767, 1'b0);
      run_traffic(ITEMS_PER_PHASE);
      apply_setting(ROT_270, 14'h3FFF, 14'd0, -16'sd50, 16'sd4000, 16'sd7, 16'sd7, 1'b0);
      run_traffic(ITEMS_PER_PHASE);
      apply_setting(ROT_270, 14'd1024, 14'd768, 16'sd4095, 16'sd0,
                    16'sd32767, -16'sd32768, 1'b1);
      run_traffic(ITEMS_PER_PHASE);
   endtask

   // random register sets, then back to the reset values
   task automatic test_random_settings();
      repeat (6) begin
         apply_setting(2'($urandom_range(0, 3)), 14'($urandom_range(1, 8192)),
                       14'($urandom_range(1, 8192)), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
         run_traffic(ITEMS_PER_PHASE);
      end
      apply_setting(RST_ROTATION, RST_SCREEN_W, RST_SCREEN_H, RST_RAW_MIN, RST_RAW_MAX,
                    RST_RAW_MIN, RST_RAW_MAX, 1'b1);
      run_traffic(ITEMS_PER_PHASE);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_ignored_events();
      test_press_release_cycle();
      test_register_extremes();
      test_random_settings();
      settle_block();
      $display("run: %0d input beats (%0d decoded events) over %0d register settings",
               beats_sent, events_counted, settings_applied + 1);
      $display("checked %0d press and %0d release points, %0d mismatches",
               press_points, release_points, mismatch_count);
      if (mismatch_count == 0 && pending_points.size() == 0) begin
         $display("touch_event_decode_rotate_scale verification clean");
      end else begin
         $display("touch_event_decode_rotate_scale verification failed");
      end
      $finish;
   end

endmodule
